// ----- design/vhb_pkg.sv -----
package vhb_pkg;

	// Operation codes carried on func
	typedef enum logic [1:0] {
		FN_SAMPLE    = 2'd0,
		FN_WRITE_BND = 2'd1,
		FN_READ_CNT  = 2'd2,
		FN_CLEAR     = 2'd3
	} func_t;

	// Word index of the configuration registers
	localparam logic REG_BIN_COUNT = 1'b0;

	// Bins in use after reset
	localparam logic [6:0] BIN_COUNT_RST = 7'd50;

	// Controller states
	typedef enum logic [3:0] {
		ST_CLR_RST,
		ST_IDLE,
		ST_SCAN,
		ST_CNT_RD,
		ST_CNT_WR,
		ST_WR_BND,
		ST_RD_CNT,
		ST_RD_DATA,
		ST_CLR_ITEM
	} state_t;

	// What the result registers load on a response
	typedef enum logic [1:0] {
		RES_ZERO,
		RES_READ,
		RES_HIT
	} res_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic cnt_rd;
		logic cnt_wr;
		logic bnd_wr;
		logic rd_req;
		logic clear;
		logic resp;
		res_t res_kind;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic used_zero;
		logic scan_hit;
		logic scan_end;
		logic clr_last;
	} stat_t;

endpackage

// ----- design/value_histogram_binner_top.sv -----
// Histogram engine for signed Q16.16 samples. Start a transaction with start while busy is low;
// each transaction returns exactly one result, shown for one cycle with done, and the receiver
// cannot stall it. A sample that lands in bin k keeps busy high until the scan has compared
// bin k and its count is updated (a miss scans every bin in use, and with no bin in use busy
// never rises), because the boundary memory has one read port and the scan compares one bin
// per cycle before a read-modify-write of the count memory.
// A boundary write, a count read and a clear each keep busy high; a clear zeroes one count
// entry per cycle. After reset the block runs the same clearing pass with busy high;
// configuration writes are taken during it. Results appear in the same cycle as busy falls,
// or the cycle after acceptance when busy never rises. The boundary table is not
// cleared by reset; bins must be written before use.
module value_histogram_binner_top #(
	parameter int MAX_BINS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic signed [31:0] value,
	input  logic [6:0]         index,
	output logic               done,
	output logic [31:0]        count,
	output logic               hit,
	output logic [5:0]         bin
);

	logic           reg_idx;
	logic           apb_wr;
	logic [6:0]     bin_count_q;
	vhb_pkg::cmd_t  cmd;
	vhb_pkg::stat_t stat;

	// Configuration register
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign apb_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q <= vhb_pkg::BIN_COUNT_RST;
		end else if (apb_wr && (reg_idx == vhb_pkg::REG_BIN_COUNT)) begin
			bin_count_q <= pwdata[6:0];
		end
	end

	assign prdata = (reg_idx == vhb_pkg::REG_BIN_COUNT) ? {25'd0, bin_count_q} : 32'd0;

	vhb_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.func  (func),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	vhb_dp #(
		.MAX_BINS(MAX_BINS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.value    (value),
		.index    (index),
		.bin_count(bin_count_q),
		.done     (done),
		.count    (count),
		.hit      (hit),
		.bin      (bin)
	);

endmodule

// ----- design/vhb_ram.sv -----
module vhb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/vhb_ctrl.sv -----
module vhb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     func,
	input  vhb_pkg::stat_t stat,
	output vhb_pkg::cmd_t  cmd,
	output logic           busy
);

	vhb_pkg::state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vhb_pkg::ST_CLR_RST;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.res_kind = vhb_pkg::RES_ZERO;
		busy         = 1'b1;
		case (state_q)
			vhb_pkg::ST_CLR_RST: begin
				cmd.clear = 1'b1;
				if (stat.clr_last) begin
					state_d = vhb_pkg::ST_IDLE;
				end
			end
			vhb_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					case (vhb_pkg::func_t'(func))
						vhb_pkg::FN_SAMPLE: begin
							if (stat.used_zero) begin
								cmd.resp = 1'b1;
							end else begin
								state_d = vhb_pkg::ST_SCAN;
							end
						end
						vhb_pkg::FN_WRITE_BND: state_d = vhb_pkg::ST_WR_BND;
						vhb_pkg::FN_READ_CNT:  state_d = vhb_pkg::ST_RD_CNT;
						vhb_pkg::FN_CLEAR:     state_d = vhb_pkg::ST_CLR_ITEM;
						default:               state_d = vhb_pkg::ST_IDLE;
					endcase
				end
			end
			vhb_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_hit) begin
					state_d = vhb_pkg::ST_CNT_RD;
				end else if (stat.scan_end) begin
					cmd.resp = 1'b1;
					state_d  = vhb_pkg::ST_IDLE;
				end
			end
			vhb_pkg::ST_CNT_RD: begin
				cmd.cnt_rd = 1'b1;
				state_d    = vhb_pkg::ST_CNT_WR;
			end
			vhb_pkg::ST_CNT_WR: begin
				cmd.cnt_wr   = 1'b1;
				cmd.resp     = 1'b1;
				cmd.res_kind = vhb_pkg::RES_HIT;
				state_d      = vhb_pkg::ST_IDLE;
			end
			vhb_pkg::ST_WR_BND: begin
				cmd.bnd_wr = 1'b1;
				cmd.resp   = 1'b1;
				state_d    = vhb_pkg::ST_IDLE;
			end
			vhb_pkg::ST_RD_CNT: begin
				cmd.rd_req = 1'b1;
				state_d    = vhb_pkg::ST_RD_DATA;
			end
			vhb_pkg::ST_RD_DATA: begin
				cmd.resp     = 1'b1;
				cmd.res_kind = vhb_pkg::RES_READ;
				state_d      = vhb_pkg::ST_IDLE;
			end
			vhb_pkg::ST_CLR_ITEM: begin
				cmd.clear = 1'b1;
				if (stat.clr_last) begin
					cmd.resp = 1'b1;
					state_d  = vhb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vhb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- design/vhb_dp.sv -----
module vhb_dp #(
	parameter int MAX_BINS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vhb_pkg::cmd_t      cmd,
	output vhb_pkg::stat_t     stat,
	input  logic signed [31:0] value,
	input  logic [6:0]         index,
	input  logic [6:0]         bin_count,
	output logic               done,
	output logic [31:0]        count,
	output logic               hit,
	output logic [5:0]         bin
);

	localparam int IW = $clog2(MAX_BINS + 1);
	localparam int PW = $clog2(MAX_BINS + 2);
	localparam int BW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

	logic [IW-1:0]      used;
	logic [PW-1:0]      ptr_q;
	logic               rvalid_q;
	logic [IW-1:0]      rtag_q;
	logic signed [31:0] value_q;
	logic signed [31:0] left_q;
	logic [6:0]         index_q;
	logic [BW-1:0]      bin_hit_q;
	logic [BW-1:0]      clr_q;
	logic               done_q;
	logic [31:0]        count_q;
	logic               hit_q;
	logic [5:0]         bin_q;

	logic               issue;
	logic               cmp_valid;
	logic               in_range;
	logic               idx_wr_ok;
	logic               idx_rd_ok;
	logic [31:0]        cnt_inc;

	logic [31:0]        b_rdata;
	logic               c_we;
	logic [BW-1:0]      c_waddr;
	logic [31:0]        c_wdata;
	logic               c_re;
	logic [BW-1:0]      c_raddr;
	logic [31:0]        c_rdata;

	// Clamp the bins in use to the table size
	assign used = (32'(bin_count) > 32'(MAX_BINS)) ? IW'(MAX_BINS) : IW'(bin_count);

	// Boundary scan: one boundary read a cycle, compare against the previous one
	assign issue     = cmd.scan && (ptr_q <= PW'(used));
	assign cmp_valid = rvalid_q && (rtag_q != '0);
	assign in_range  = (value_q >= left_q) && (value_q < $signed(b_rdata));

	assign idx_wr_ok = 32'(index_q) <= 32'(MAX_BINS);
	assign idx_rd_ok = 32'(index_q) < 32'(MAX_BINS);

	assign cnt_inc = (c_rdata == '1) ? c_rdata : c_rdata + 32'd1;

	assign stat.used_zero = (used == '0);
	assign stat.scan_hit  = cmp_valid && in_range;
	assign stat.scan_end  = cmp_valid && !in_range && (rtag_q == used);
	assign stat.clr_last  = (clr_q == BW'(MAX_BINS - 1));

	// Boundary table
	vhb_ram #(
		.WIDTH(32),
		.DEPTH(MAX_BINS + 1)
	) u_bnd_ram (
		.clk  (clk),
		.we   (cmd.bnd_wr && idx_wr_ok),
		.waddr(IW'(index_q)),
		.wdata(value_q),
		.re   (issue),
		.raddr(ptr_q[IW-1:0]),
		.rdata(b_rdata)
	);

	// Count memory ports: clear sweep or increment write, bin or host read
	assign c_we    = cmd.clear || cmd.cnt_wr;
	assign c_waddr = cmd.clear ? clr_q : bin_hit_q;
	assign c_wdata = cmd.clear ? 32'd0 : cnt_inc;
	assign c_re    = cmd.cnt_rd || cmd.rd_req;
	assign c_raddr = cmd.cnt_rd ? bin_hit_q : BW'(index_q);

	vhb_ram #(
		.WIDTH(32),
		.DEPTH(MAX_BINS)
	) u_cnt_ram (
		.clk  (clk),
		.we   (c_we),
		.waddr(c_waddr),
		.wdata(c_wdata),
		.re   (c_re),
		.raddr(c_raddr),
		.rdata(c_rdata)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			rvalid_q <= 1'b0;
			clr_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			rvalid_q <= issue;
			done_q   <= cmd.resp;
			if (cmd.load) begin
				ptr_q <= '0;
			end else if (issue) begin
				ptr_q <= ptr_q + PW'(1);
			end
			if (cmd.clear) begin
				clr_q <= stat.clr_last ? '0 : clr_q + BW'(1);
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value;
			index_q <= index;
		end
		if (issue) begin
			rtag_q <= ptr_q[IW-1:0];
		end
		if (rvalid_q) begin
			left_q <= $signed(b_rdata);
		end
		if (cmd.scan && stat.scan_hit) begin
			bin_hit_q <= BW'(rtag_q - IW'(1));
		end
		if (cmd.resp) begin
			case (cmd.res_kind)
				vhb_pkg::RES_READ: begin
					count_q <= idx_rd_ok ? c_rdata : 32'd0;
					hit_q   <= 1'b0;
					bin_q   <= 6'd0;
				end
				vhb_pkg::RES_HIT: begin
					count_q <= cnt_inc;
					hit_q   <= 1'b1;
					bin_q   <= 6'(bin_hit_q);
				end
				default: begin
					count_q <= 32'd0;
					hit_q   <= 1'b0;
					bin_q   <= 6'd0;
				end
			endcase
		end
	end

	assign done  = done_q;
	assign count = count_q;
	assign hit   = hit_q;
	assign bin   = bin_q;

endmodule

// ----- bench/tb_value_histogram_binner_top.sv -----
`timescale 1ns / 100ps

module tb_value_histogram_binner_top;

	localparam int BIN_MAX = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [2:0] BIN_CNT_ADDR = {vhb_pkg::REG_BIN_COUNT, 2'b00};
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

	typedef struct packed {
		logic [31:0] count;
		logic        hit;
		logic [5:0]  bin;
	} bin_res_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               start;
	logic               busy;
	vhb_pkg::func_t     drv_func;
	logic signed [31:0] drv_value;
	logic [6:0]         drv_index;
	logic               done;
	logic [31:0]        count;
	logic               hit;
	logic [5:0]         bin;

	// Shadow of the block state
	logic signed [31:0] bin_edges [0:BIN_MAX];
	logic [31:0]        histo_counts [0:BIN_MAX-1];
	logic [6:0]         bins_cfg;

	bin_res_t bin_results_due [$];
	int       mismatch_cnt;
	int       cycle_cnt;

	value_histogram_binner_top #(
		.MAX_BINS(BIN_MAX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.func(drv_func),
		.value(drv_value),
		.index(drv_index),
		.done(done),
		.count(count),
		.hit(hit),
		.bin(bin)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Apply one transaction to the shadow state and return its result
	function automatic bin_res_t histogram_update(vhb_pkg::func_t f, logic signed [31:0] v,
			logic [6:0] idx);
		bin_res_t r;
		int used;
		r = '0;
		case (f)
			vhb_pkg::FN_SAMPLE: begin
				used = (bins_cfg > BIN_MAX) ? BIN_MAX : int'(bins_cfg);
				// first bin in use that holds the sample wins
				for (int b = 0; b < used && !r.hit; b++) begin
					if (v >= bin_edges[b] && v < bin_edges[b+1]) begin
						if (histo_counts[b] != 32'hFFFF_FFFF)
							histo_counts[b] = histo_counts[b] + 1;
						r.count = histo_counts[b];
						r.hit = 1'b1;
						r.bin = 6'(b);
					end
				end
			end
			vhb_pkg::FN_WRITE_BND: begin
				if (idx <= BIN_MAX)
					bin_edges[idx] = v;
			end
			vhb_pkg::FN_READ_CNT: begin
				if (idx < BIN_MAX)
					r.count = histo_counts[idx];
			end
			default: begin
				for (int b = 0; b < BIN_MAX; b++)
					histo_counts[b] = '0;
			end
		endcase
		return r;
	endfunction

	// Pick a sample: mostly inside a bin in use, on its edges, or anywhere
	function automatic logic signed [31:0] pick_sample();
		int used;
		int b;
		int w;
		longint span;
		longint off;
		used = (bins_cfg > BIN_MAX) ? BIN_MAX : int'(bins_cfg);
		w = $urandom_range(0, 9);
		if (used == 0 || w == 0)
			return $urandom;
		b = $urandom_range(0, used - 1);
		if (w <= 2)
			return bin_edges[b];
		if (w == 3)
			return bin_edges[b+1] - 1;
		span = longint'(bin_edges[b+1]) - longint'(bin_edges[b]);
		if (span <= 0)
			return bin_edges[b];
		off = longint'($urandom) % span;
		return 32'(longint'(bin_edges[b]) + off);
	endfunction

	// Drive one transaction and hold it until the block takes it
	task automatic send_op(vhb_pkg::func_t f, logic signed [31:0] v, logic [6:0] idx);
		@(negedge clk);
		start <= 1'b1;
		drv_func <= f;
		drv_value <= v;
		drv_index <= idx;
		do @(posedge clk); while (busy);
		bin_results_due.push_back(histogram_update(f, v, idx));
	endtask

	task automatic idle_gap(int n);
		repeat (n) @(negedge clk) start <= 1'b0;
	endtask

	// Drop start and wait until every result is back and the block is idle
	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (bin_results_due.size() != 0)
			@(posedge clk);
		do @(posedge clk); while (busy);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_bin_count(logic [6:0] n);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= BIN_CNT_ADDR;
		pwdata <= 32'(n);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		bins_cfg = n;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Write a full non-descending boundary table with uneven bin widths
	task automatic load_edges(bit full_span);
		logic signed [31:0] e;
		int step;
		e = full_span ? Q_MIN : -$signed(32'($urandom_range(0, 32'h4000_0000)));
		for (int i = 0; i <= BIN_MAX; i++) begin
			if (full_span && i == BIN_MAX)
				e = Q_MAX;
			send_op(vhb_pkg::FN_WRITE_BND, e, 7'(i));
			step = ($urandom_range(0, 15) == 0) ? 0 :
				$urandom_range(1, 1 << $urandom_range(4, 24));
			e = e + step;
		end
	endtask

	task automatic test_reset_state();
		wait_idle();
		send_op(vhb_pkg::FN_READ_CNT, $urandom, 7'd0);
		send_op(vhb_pkg::FN_READ_CNT, $urandom, 7'd63);
		send_op(vhb_pkg::FN_READ_CNT, $urandom, 7'd127);
	endtask

	// Four bins: [min,-1) [-1,0) an empty bin, then [0,max)
	task automatic test_basic_bins();
		wait_idle();
		write_bin_count(7'd4);
		send_op(vhb_pkg::FN_WRITE_BND, Q_MIN, 7'd0);
		send_op(vhb_pkg::FN_WRITE_BND, -Q_ONE, 7'd1);
		send_op(vhb_pkg::FN_WRITE_BND, 32'sd0, 7'd2);
		send_op(vhb_pkg::FN_WRITE_BND, 32'sd0, 7'd3);
		send_op(vhb_pkg::FN_WRITE_BND, Q_MAX, 7'd4);
		send_op(vhb_pkg::FN_SAMPLE, Q_MIN, 7'd127);
		send_op(vhb_pkg::FN_SAMPLE, -Q_ONE, 7'd0);
		send_op(vhb_pkg::FN_SAMPLE, -32'sh0000_8000, 7'd0);
		send_op(vhb_pkg::FN_SAMPLE, 32'sd0, 7'd0);
		send_op(vhb_pkg::FN_SAMPLE, Q_MAX, 7'd0);
		send_op(vhb_pkg::FN_SAMPLE, Q_MAX - 1, 7'd0);
		send_op(vhb_pkg::FN_READ_CNT, $urandom, 7'd3);
	endtask

	task automatic test_ignored_writes();
		send_op(vhb_pkg::FN_WRITE_BND, 32'sd0, 7'd65);
		send_op(vhb_pkg::FN_WRITE_BND, Q_MIN, 7'd127);
		send_op(vhb_pkg::FN_SAMPLE, 32'sd5, 7'd0);
		send_op(vhb_pkg::FN_READ_CNT, $urandom, 7'd64);
	endtask

	// Push a boundary up so one bin grows and the next one turns reversed
	task automatic test_reversed_bin();
		send_op(vhb_pkg::FN_WRITE_BND, Q_ONE, 7'd2);
		send_op(vhb_pkg::FN_SAMPLE, 32'sh0000_8000, 7'd0);
		send_op(vhb_pkg::FN_SAMPLE, Q_ONE, 7'd0);
	endtask

	task automatic test_clear();
		send_op(vhb_pkg::FN_CLEAR, $urandom, 7'(($urandom)));
		send_op(vhb_pkg::FN_READ_CNT, $urandom, 7'd3);
		send_op(vhb_pkg::FN_READ_CNT, $urandom, 7'd1);
	endtask

	task automatic test_zero_bins();
		wait_idle();
		write_bin_count(7'd0);
		send_op(vhb_pkg::FN_SAMPLE, 32'sd0, 7'd0);
		send_op(vhb_pkg::FN_SAMPLE, Q_MIN, 7'd0);
	endtask

	// Mixed traffic at one bin count
	task automatic test_random_phase(logic [6:0] n_bins, int n_items, bit gaps);
		int r;
		vhb_pkg::func_t f;
		logic signed [31:0] v;
		logic [6:0] idx;
		wait_idle();
		write_bin_count(n_bins);
		for (int k = 0; k < n_items; k++) begin
			r = $urandom_range(0, 99);
			idx = 7'($urandom);
			v = $urandom;
			if (r < 76) begin
				f = vhb_pkg::FN_SAMPLE;
				v = pick_sample();
			end else if (r < 84) begin
				f = vhb_pkg::FN_WRITE_BND;
				if ($urandom_range(0, 5) != 0)
					idx = 7'($urandom_range(0, BIN_MAX));
			end else if (r < 98) begin
				f = vhb_pkg::FN_READ_CNT;
				if ($urandom_range(0, 1) == 0)
					idx = 7'($urandom_range(0, BIN_MAX - 1));
			end else begin
				f = vhb_pkg::FN_CLEAR;
			end
			send_op(f, v, idx);
			if (gaps && $urandom_range(0, 3) == 0)
				idle_gap($urandom_range(1, 10));
			if (gaps && $urandom_range(0, 99) == 0)
				wait_idle();
		end
	endtask

	// Check each result against the oldest outstanding one
	always @(posedge clk) begin : result_check
		bin_res_t want;
		if (arst_n && done) begin
			if (bin_results_due.size() == 0) begin
				if (mismatch_cnt < 10)
					$display("%0t: unexpected result count %h hit %0d bin %0d",
						$time, count, hit, bin);
				mismatch_cnt++;
			end else begin
				want = bin_results_due.pop_front();
				if (count !== want.count || hit !== want.hit || bin !== want.bin) begin
					if (mismatch_cnt < 10)
						$display("%0t: mismatch count %h/%h hit %0d/%0d bin %0d/%0d (exp/act)",
							$time, want.count, count, want.hit, hit, want.bin, bin);
					mismatch_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb_value_histogram_binner_top: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		drv_func = vhb_pkg::FN_SAMPLE;
		drv_value = '0;
		drv_index = '0;
		mismatch_cnt = 0;
		cycle_cnt = 0;
		bins_cfg = vhb_pkg::BIN_COUNT_RST;
		for (int b = 0; b <= BIN_MAX; b++)
			bin_edges[b] = '0;
		for (int b = 0; b < BIN_MAX; b++)
			histo_counts[b] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_basic_bins();
		test_ignored_writes();
		test_reversed_bin();
		test_clear();
		test_zero_bins();

		load_edges(1'b1);
		test_random_phase(7'd64, 250, 1'b1);
		test_random_phase(7'd1, 100, 1'b1);
		load_edges(1'b0);
		test_random_phase(7'd127, 200, 1'b1);
		test_random_phase(7'($urandom_range(2, 63)), 200, 1'b1);
		test_random_phase(7'd0, 30, 1'b1);
		load_edges(1'b1);
		test_random_phase(7'($urandom_range(1, 127)), 220, 1'b0);

		wait_idle();
		repeat (BIN_MAX + 8) @(posedge clk);
		if (mismatch_cnt == 0 && bin_results_due.size() == 0) begin
			$display("tb_value_histogram_binner_top: PASS");
		end else begin
			$display("tb_value_histogram_binner_top: FAIL");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/vhb_pkg.sv
design/vhb_ram.sv
design/vhb_ctrl.sv
design/vhb_dp.sv
design/value_histogram_binner_top.sv
bench/tb_value_histogram_binner_top.sv
